// ===== design/tist_pkg.sv =====
`timescale 1ns / 1ps
// Package for the tracked ID slot table: request codes, field widths and the
// control structs passed between the sequencer and the storage modules.
package tist_pkg;

  localparam int FUNC_W = 4;
  localparam int ID_W   = 32;
  localparam int DATA_W = 64;
  localparam int CNT_W  = 6;

  localparam logic [FUNC_W-1:0] FN_ADD       = 4'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE    = 4'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP    = 4'd2;
  localparam logic [FUNC_W-1:0] FN_MARK_A    = 4'd3;
  localparam logic [FUNC_W-1:0] FN_MARK_N    = 4'd4;
  localparam logic [FUNC_W-1:0] FN_MARK_O    = 4'd5;
  localparam logic [FUNC_W-1:0] FN_UNMARK_N  = 4'd6;
  localparam logic [FUNC_W-1:0] FN_UNMARK_O  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_REASSIGN  = 4'd8;
  localparam logic [FUNC_W-1:0] FN_CLR_N     = 4'd9;
  localparam logic [FUNC_W-1:0] FN_CLR_O     = 4'd10;
  localparam logic [FUNC_W-1:0] FN_CLR_ALL   = 4'd11;
  localparam logic [FUNC_W-1:0] FN_UNMARK_A  = 4'd12;

  typedef struct packed {
    logic wr_id;
    logic wr_pay;
    logic set_used;
    logic clr_used;
    logic clr_all;
  } slot_ctl_t;

  typedef struct packed {
    logic add;
    logic drop;
    logic clear;
  } set_ctl_t;

endpackage

// ===== design/tist_cmd_if.sv =====
`timescale 1ns / 1ps
// Request channel of the tracked ID slot table.
// Depends on tist_pkg for the field widths.
interface tist_cmd_if import tist_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   id;
  logic [DATA_W-1:0] payload;

  modport source (output valid, func, id, payload, input ready);
  modport sink (input valid, func, id, payload, output ready);
endinterface

// ===== design/tist_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the tracked ID slot table.
// Depends on tist_pkg for the field widths.
interface tist_rsp_if import tist_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic              found;
  logic [DATA_W-1:0] payload_out;
  logic [ID_W-1:0]   primary_id;
  logic [CNT_W-1:0]  free_slots;
  logic [CNT_W-1:0]  active_count;
  logic [CNT_W-1:0]  new_count;
  logic [CNT_W-1:0]  old_count;
  logic              is_active;
  logic              is_new;
  logic              is_old;
  logic              set_overflow;

  modport source (output valid, status, found, payload_out, primary_id, free_slots,
                  active_count, new_count, old_count, is_active, is_new, is_old,
                  set_overflow, input ready);
  modport sink (input valid, status, found, payload_out, primary_id, free_slots,
                active_count, new_count, old_count, is_active, is_new, is_old,
                set_overflow, output ready);
endinterface

// ===== design/tist_slot_mem.sv =====
`timescale 1ns / 1ps
// Slot storage: ID and payload memories with registered reads and a
// bank of occupancy flops. Depends on tist_pkg for slot_ctl_t.
module tist_slot_mem import tist_pkg::*; #(
  parameter int SLOTS        = 32,
  parameter int PAYLOAD_BITS = 64,
  localparam int SW          = $clog2(SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  slot_ctl_t               ctl,
  input  logic [SW-1:0]           waddr,
  input  logic [ID_W-1:0]         wid,
  input  logic [PAYLOAD_BITS-1:0] wpay,
  input  logic [SW-1:0]           raddr,
  output logic [ID_W-1:0]         rid,
  output logic [PAYLOAD_BITS-1:0] rpay,
  output logic [SLOTS-1:0]        used
);

  logic [ID_W-1:0]         id_mem  [SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.wr_id) begin
      id_mem[waddr] <= wid;
    end
    rid <= id_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_pay) begin
      pay_mem[waddr] <= wpay;
    end
    rpay <= pay_mem[raddr];
  end

  // A slot whose occupancy bit is low reads as empty whatever its ID word holds.
  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      used <= '0;
    end else if (ctl.set_used) begin
      used[waddr] <= 1'b1;
    end else if (ctl.clr_used) begin
      used[waddr] <= 1'b0;
    end
  end

endmodule

// ===== design/tist_set_mem.sv =====
`timescale 1ns / 1ps
// One ID set: an entry memory with a registered read, a fill count and
// a shift engine that closes the gap left by a removed entry. Uses tist_pkg.
module tist_set_mem import tist_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int DW   = $clog2(DEPTH),
  localparam int FW   = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  set_ctl_t        ctl,
  input  logic [DW-1:0]   idx,
  input  logic [ID_W-1:0] wid,
  input  logic [DW-1:0]   raddr,
  output logic [ID_W-1:0] rdata,
  output logic [FW-1:0]   fill,
  output logic            busy
);

  logic [ID_W-1:0] mem [DEPTH];
  logic [FW-1:0]   rd_idx;
  logic            pend;
  logic [DW-1:0]   pend_idx;
  logic            shift_wr;
  logic [DW-1:0]   ra;

  assign shift_wr = busy && pend;
  assign ra       = busy ? rd_idx[DW-1:0] : raddr;

  always_ff @(posedge clk) begin
    if (ctl.add) begin
      mem[fill[DW-1:0]] <= wid;
    end else if (shift_wr) begin
      mem[pend_idx] <= rdata;
    end
    rdata <= mem[ra];
  end

  // Each entry above the removed one is read and written one place lower,
  // one entry a cycle while no add, clear or drop arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      busy <= 1'b0;
      pend <= 1'b0;
    end else if (ctl.clear) begin
      fill <= '0;
    end else if (ctl.add) begin
      fill <= fill + FW'(1);
    end else if (ctl.drop) begin
      busy   <= 1'b1;
      rd_idx <= FW'(idx) + FW'(1);
      pend   <= 1'b0;
    end else if (busy) begin
      if (rd_idx < fill) begin
        rd_idx   <= rd_idx + FW'(1);
        pend     <= 1'b1;
        pend_idx <= DW'(rd_idx - FW'(1));
      end else begin
        pend <= 1'b0;
        if (!pend) begin
          busy <= 1'b0;
          fill <= fill - FW'(1);
        end
      end
    end
  end

endmodule

// ===== design/tracked_id_slot_table.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Contents
// cmd       in         func, id, payload
// rsp       out        status, found, payload_out, primary_id, counts, flags
//
// Every request first scans the slot table and the three sets side by side,
// one entry a cycle over max(SLOTS, SET_DEPTH) entries, skipped for ID zero.
// A new slot then searches for the next empty slot; a removal shifts a set
// down; a primary search reads the active set once more.
// Synchronous reset empties all tables at once. A waiting result does not
// block the next request, which is held only until its own result is loaded.
// Depends on tist_pkg, tist_cmd_if, tist_rsp_if, tist_slot_mem, tist_set_mem.
module tracked_id_slot_table import tist_pkg::*; #(
  parameter int SLOTS        = 32,
  parameter int SET_DEPTH    = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  tist_cmd_if.sink   cmd,
  tist_rsp_if.source rsp
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int DW = $clog2(SET_DEPTH);
  localparam int FW = $clog2(SET_DEPTH + 1);
  localparam int N  = (SLOTS > SET_DEPTH) ? SLOTS : SET_DEPTH;
  localparam int IW = $clog2(N + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_NFREE = 3'd3;
  localparam logic [2:0] ST_DROP  = 3'd4;
  localparam logic [2:0] ST_MIN   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]              state;
  logic [FUNC_W-1:0]       func_r;
  logic [ID_W-1:0]         id_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [IW-1:0]           idx;
  logic                    pend;
  logic [IW-1:0]           pend_idx;
  logic                    s_hit, a_hit, n_hit, o_hit;
  logic [SW-1:0]           s_k;
  logic [DW-1:0]           a_k, n_k, o_k;
  logic [PAYLOAD_BITS-1:0] pay_hit;
  logic                    status_r, ovf_r, need_pick;
  logic [SW-1:0]           next_free;
  logic [CW-1:0]           free_count;
  logic [ID_W-1:0]         primary;
  logic [ID_W-1:0]         min_id;

  slot_ctl_t               slot_ctl;
  logic [SW-1:0]           slot_waddr;
  logic [ID_W-1:0]         rid;
  logic [PAYLOAD_BITS-1:0] rpay;
  logic [SLOTS-1:0]        used;

  set_ctl_t                a_ctl, n_ctl, o_ctl;
  logic [ID_W-1:0]         a_rd, n_rd, o_rd;
  logic [FW-1:0]           a_fill, n_fill, o_fill;
  logic                    a_busy, n_busy, o_busy;

  logic                    issue;
  logic                    a_room, n_room, o_room;
  logic [SW-1:0]           nf_wrap;
  logic                    rsp_free;
  logic [2:0]              exec_state;
  logic                    exec_pick;

  assign cmd.ready = (state == ST_IDLE);
  assign a_room    = a_fill < FW'(SET_DEPTH);
  assign n_room    = n_fill < FW'(SET_DEPTH);
  assign o_room    = o_fill < FW'(SET_DEPTH);
  assign nf_wrap   = (next_free == SW'(SLOTS - 1)) ? '0 : next_free + SW'(1);
  assign issue     = (state == ST_MIN) ? (idx < IW'(a_fill)) : (idx < IW'(N));
  assign rsp_free  = !rsp.valid || rsp.ready;

  tist_slot_mem #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_slots (
    .clk(clk), .rst(rst), .ctl(slot_ctl), .waddr(slot_waddr), .wid(id_r),
    .wpay(pay_r), .raddr(idx[SW-1:0]), .rid(rid), .rpay(rpay), .used(used)
  );

  tist_set_mem #(.DEPTH(SET_DEPTH)) u_active (
    .clk(clk), .rst(rst), .ctl(a_ctl), .idx(a_k), .wid(id_r),
    .raddr(idx[DW-1:0]), .rdata(a_rd), .fill(a_fill), .busy(a_busy)
  );

  tist_set_mem #(.DEPTH(SET_DEPTH)) u_new (
    .clk(clk), .rst(rst), .ctl(n_ctl), .idx(n_k), .wid(id_r),
    .raddr(idx[DW-1:0]), .rdata(n_rd), .fill(n_fill), .busy(n_busy)
  );

  tist_set_mem #(.DEPTH(SET_DEPTH)) u_old (
    .clk(clk), .rst(rst), .ctl(o_ctl), .idx(o_k), .wid(id_r),
    .raddr(idx[DW-1:0]), .rdata(o_rd), .fill(o_fill), .busy(o_busy)
  );

  // Storage commands are issued only in the single execute cycle.
  always_comb begin
    slot_ctl   = '0;
    slot_waddr = s_k;
    a_ctl      = '0;
    n_ctl      = '0;
    o_ctl      = '0;
    if (state == ST_EXEC) begin
      unique case (func_r)
        FN_ADD: begin
          if (free_count != '0 && id_r != '0) begin
            slot_ctl.wr_pay = 1'b1;
            if (!s_hit) begin
              slot_ctl.wr_id    = 1'b1;
              slot_ctl.set_used = 1'b1;
              slot_waddr        = next_free;
            end
          end
        end
        FN_REMOVE: begin
          if (s_hit) begin
            slot_ctl.clr_used = 1'b1;
            a_ctl.drop        = a_hit;
            n_ctl.drop        = n_hit;
          end
        end
        FN_MARK_A:   a_ctl.add   = (id_r != '0) && !a_hit && a_room;
        FN_MARK_N:   n_ctl.add   = (id_r != '0) && !n_hit && n_room;
        FN_MARK_O:   o_ctl.add   = (id_r != '0) && !o_hit && o_room;
        FN_UNMARK_A: a_ctl.drop  = a_hit;
        FN_UNMARK_N: n_ctl.drop  = n_hit;
        FN_UNMARK_O: o_ctl.drop  = o_hit;
        FN_CLR_N:    n_ctl.clear = 1'b1;
        FN_CLR_O:    o_ctl.clear = 1'b1;
        FN_CLR_ALL: begin
          slot_ctl.clr_all = 1'b1;
          a_ctl.clear      = 1'b1;
          n_ctl.clear      = 1'b1;
          o_ctl.clear      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Where the execute cycle goes next, and whether a primary search follows.
  always_comb begin
    exec_state = ST_DONE;
    exec_pick  = 1'b0;
    case (func_r)
      FN_ADD: begin
        if (free_count != '0 && id_r != '0 && !s_hit && free_count != CW'(1)) begin
          exec_state = ST_NFREE;
        end
      end
      FN_REMOVE: begin
        if (s_hit) begin
          exec_state = ST_DROP;
          exec_pick  = (id_r == primary);
        end
      end
      FN_UNMARK_A: begin
        if (id_r != '0) begin
          exec_state = ST_DROP;
          exec_pick  = (id_r == primary);
        end
      end
      FN_UNMARK_N: exec_state = ST_DROP;
      FN_UNMARK_O: exec_state = ST_DROP;
      FN_REASSIGN: begin
        if (!(id_r != '0 && a_hit)) begin
          exec_state = ST_MIN;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      next_free  <= '0;
      free_count <= CW'(SLOTS);
      primary    <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != ST_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            func_r   <= cmd.func;
            id_r     <= cmd.id;
            pay_r    <= cmd.payload[PAYLOAD_BITS-1:0];
            idx      <= '0;
            pend     <= 1'b0;
            s_hit    <= 1'b0;
            a_hit    <= 1'b0;
            n_hit    <= 1'b0;
            o_hit    <= 1'b0;
            status_r <= 1'b0;
            ovf_r    <= 1'b0;
            state    <= (cmd.id == '0) ? ST_EXEC : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            idx <= idx + IW'(1);
          end
          pend     <= issue;
          pend_idx <= idx;
          if (pend) begin
            if (pend_idx < IW'(SLOTS) && used[pend_idx[SW-1:0]] && rid == id_r) begin
              s_hit   <= 1'b1;
              s_k     <= pend_idx[SW-1:0];
              pay_hit <= rpay;
            end
            if (pend_idx < IW'(a_fill) && a_rd == id_r) begin
              a_hit <= 1'b1;
              a_k   <= pend_idx[DW-1:0];
            end
            if (pend_idx < IW'(n_fill) && n_rd == id_r) begin
              n_hit <= 1'b1;
              n_k   <= pend_idx[DW-1:0];
            end
            if (pend_idx < IW'(o_fill) && o_rd == id_r) begin
              o_hit <= 1'b1;
              o_k   <= pend_idx[DW-1:0];
            end
            if (!issue) begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          state     <= exec_state;
          need_pick <= exec_pick;
          idx       <= '0;
          pend      <= 1'b0;
          min_id    <= '0;
          // The hit flags are turned into membership after the request.
          case (func_r)
            FN_ADD: begin
              if (free_count == '0) begin
                status_r <= 1'b1;
              end else if (id_r != '0) begin
                s_hit <= 1'b1;
                if (!s_hit) begin
                  free_count <= free_count - CW'(1);
                  if (free_count != CW'(1)) begin
                    next_free <= nf_wrap;
                  end
                end
              end
            end
            FN_REMOVE: begin
              if (s_hit) begin
                s_hit <= 1'b0;
                a_hit <= 1'b0;
                n_hit <= 1'b0;
                if (free_count == '0) begin
                  next_free <= s_k;
                end
                free_count <= free_count + CW'(1);
              end
            end
            FN_MARK_A: begin
              if (id_r != '0) begin
                if (!a_hit) begin
                  if (a_room) begin
                    a_hit <= 1'b1;
                  end else begin
                    ovf_r <= 1'b1;
                  end
                end
                if (a_fill == '0 || (a_fill == FW'(1) && a_hit)) begin
                  primary <= id_r;
                end
              end
            end
            FN_MARK_N: begin
              if (id_r != '0 && !n_hit) begin
                if (n_room) begin
                  n_hit <= 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
            end
            FN_MARK_O: begin
              if (id_r != '0 && !o_hit) begin
                if (o_room) begin
                  o_hit <= 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
            end
            FN_UNMARK_A: begin
              if (id_r != '0) begin
                a_hit <= 1'b0;
              end
            end
            FN_UNMARK_N: n_hit <= 1'b0;
            FN_UNMARK_O: o_hit <= 1'b0;
            FN_REASSIGN: begin
              if (id_r != '0 && a_hit) begin
                primary <= id_r;
              end
            end
            FN_CLR_N: n_hit <= 1'b0;
            FN_CLR_O: o_hit <= 1'b0;
            FN_CLR_ALL: begin
              s_hit      <= 1'b0;
              a_hit      <= 1'b0;
              n_hit      <= 1'b0;
              o_hit      <= 1'b0;
              primary    <= '0;
              next_free  <= '0;
              free_count <= CW'(SLOTS);
            end
            default: begin
            end
          endcase
        end
        ST_NFREE: begin
          // At least one slot is empty here, so the walk always ends.
          if (!used[next_free]) begin
            state <= ST_DONE;
          end else begin
            next_free <= nf_wrap;
          end
        end
        ST_DROP: begin
          if (!a_busy && !n_busy && !o_busy) begin
            state <= need_pick ? ST_MIN : ST_DONE;
          end
        end
        ST_MIN: begin
          if (issue) begin
            idx <= idx + IW'(1);
          end
          pend <= issue;
          if (pend && (min_id == '0 || a_rd < min_id)) begin
            min_id <= a_rd;
          end
          if (!issue && !pend) begin
            primary <= min_id;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= status_r;
            rsp.found        <= s_hit;
            rsp.payload_out  <= (func_r == FN_LOOKUP && s_hit) ? DATA_W'(pay_hit) : '0;
            rsp.primary_id   <= primary;
            rsp.free_slots   <= CNT_W'(free_count);
            rsp.active_count <= CNT_W'(a_fill);
            rsp.new_count    <= CNT_W'(n_fill);
            rsp.old_count    <= CNT_W'(o_fill);
            rsp.is_active    <= a_hit;
            rsp.is_new       <= n_hit;
            rsp.is_old       <= o_hit;
            rsp.set_overflow <= ovf_r;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/tist_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the tracked ID slot table, bound to the top level.
// Depends on tist_pkg for the field widths.
module tist_checker import tist_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_status,
  input logic [ID_W-1:0]   rsp_primary,
  input logic [CNT_W-1:0]  rsp_free
);

  // A stalled result keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_primary) && $stable(rsp_status))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown straight after reset");

  // A refused add only happens on a full table, and it changes nothing.
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_free == '0)
    else $error("add refused with free slots left");

  // A request is worked on alone: nothing more is taken the cycle after.
  a_one_at_once: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second request taken while one is in work");

endmodule

bind tracked_id_slot_table tist_checker u_tist_checker (
  .clk(clk),
  .rst(rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_status(rsp.status),
  .rsp_primary(rsp.primary_id),
  .rsp_free(rsp.free_slots)
);
